### hw/rtl/lrf_pkg.sv
`default_nettype none

package lrf_pkg;

    // Default screen size
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    // Field widths fixed by the item formats
    localparam int COORD_W    = 8;
    localparam int KIND_W     = 2;
    localparam int READ_IDX_W = 10;
    localparam int BYTE_W     = 8;
    localparam int ROWS_PER_PAGE = 8;

    // Bresenham error term: one sign bit plus headroom over a coordinate
    localparam int ERR_W = COORD_W + 2;

    localparam logic [BYTE_W-1:0] BYTE_CLEAR = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_SET   = 8'hFF;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [COORD_W-1:0]    start_x;
        logic [COORD_W-1:0]    start_y;
        logic [COORD_W-1:0]    end_x;
        logic [COORD_W-1:0]    end_y;
        logic                  pen_colour;
        logic [READ_IDX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [KIND_W-1:0] done_kind;
    } t_out_item;

    typedef struct packed {
        logic draw_inverted;
    } t_cfg_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_READ_WAIT,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/lrf_stream_if.sv
`default_nettype none

interface lrf_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/line_raster_framebuffer.sv
`default_nettype none

// Monochrome page-organised frame store with a line drawer, a whole-store fill
// and a byte read port. Pixel (x, y) sits in byte x + (y/8)*SCREEN_WIDTH, bit
// y%8. All state lives in one single-port synchronous RAM of
// ceil(SCREEN_HEIGHT/8)*SCREEN_WIDTH bytes (1024 at the defaults), with a
// registered read. Items are taken one at a time; every item gives exactly
// one result item, held in an output register so that the next item can be
// accepted while the result waits. Through the single RAM port a line reads
// each pixel's byte, then modifies and writes it back, its end points clamped
// to the screen; a fill sweeps one byte per cycle. After reset the RAM is
// cleared, and no item is accepted during the clear; configuration writes
// are taken at any time. The draw_inverted register flips the pen colour of
// line pixels only.
module line_raster_framebuffer
    import lrf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrf_stream_if.sink   i_item,
    lrf_stream_if.source o_result,
    lrf_stream_if.sink   i_cfg
);

    localparam int PAGES       = (SCREEN_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
    localparam int STORE_BYTES = PAGES * SCREEN_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    // Clamp a coordinate to limit - 1
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-1:0] v,
        input logic [COORD_W:0]   lim
    );
        logic [COORD_W:0] lim_m1;
        lim_m1 = lim - 1'b1;
        return ({1'b0, v} >= lim) ? lim_m1[COORD_W-1:0] : v;
    endfunction

    // ---------------------------------------------------------------
    // Frame store RAM
    // ---------------------------------------------------------------
    logic [BYTE_W-1:0] r_frame [STORE_BYTES];
    logic [BYTE_W-1:0] r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_frame[mem_addr];
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [ADDR_W-1:0]      r_sweep, n_sweep;
    logic [BYTE_W-1:0]      r_fill, n_fill;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [BYTE_W-1:0]      r_res_data, n_res_data;

    // Line walker
    logic [COORD_W-1:0]     r_x, n_x, r_y, n_y;
    logic [COORD_W-1:0]     r_x1, n_x1, r_y1, n_y1;
    logic [COORD_W-1:0]     r_dx, n_dx, r_dy, n_dy;
    logic                   r_sx, n_sx, r_sy, n_sy;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic                   r_white, n_white;

    logic                   r_inv;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    logic item_acc;
    logic out_free;

    assign i_item.ready     = (r_state == ST_IDLE);
    assign item_acc         = i_item.valid && (r_state == ST_IDLE);
    assign out_free         = !r_out_valid || o_result.ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;
    assign i_cfg.ready      = 1'b1;

    // ---------------------------------------------------------------
    // Incoming item decode and line set-up
    // ---------------------------------------------------------------
    t_in_item           in_item;
    logic [COORD_W-1:0] cx0, cy0, cx1, cy1, in_dx, in_dy;
    logic               in_sx, in_sy;
    logic               rd_in_range;
    logic [COORD_W-1:0] half_dx, half_dy;

    assign in_item = i_item.payload;
    assign cx0 = clamp_coord(in_item.start_x, (COORD_W+1)'(SCREEN_WIDTH));
    assign cy0 = clamp_coord(in_item.start_y, (COORD_W+1)'(SCREEN_HEIGHT));
    assign cx1 = clamp_coord(in_item.end_x,   (COORD_W+1)'(SCREEN_WIDTH));
    assign cy1 = clamp_coord(in_item.end_y,   (COORD_W+1)'(SCREEN_HEIGHT));
    assign in_sx = cx0 < cx1;
    assign in_sy = cy0 < cy1;
    assign in_dx = in_sx ? cx1 - cx0 : cx0 - cx1;
    assign in_dy = in_sy ? cy1 - cy0 : cy0 - cy1;
    assign half_dx = in_dx >> 1;
    assign half_dy = in_dy >> 1;
    assign rd_in_range = 32'(in_item.read_index) < STORE_BYTES;

    // ---------------------------------------------------------------
    // Pixel step
    // ---------------------------------------------------------------
    logic signed [ERR_W-1:0] dx_s, dy_s, neg_dx, err_dec, err_inc;
    logic                    step_x, step_y, at_end;
    logic [ADDR_W-1:0]       pix_addr;
    logic [BYTE_W-1:0]       pix_mask;

    assign dx_s    = $signed({2'b00, r_dx});
    assign dy_s    = $signed({2'b00, r_dy});
    assign neg_dx  = -dx_s;
    assign step_x  = r_err > neg_dx;
    assign step_y  = r_err < dy_s;
    assign err_dec = step_x ? dy_s : $signed(ERR_W'(0));
    assign err_inc = step_y ? dx_s : $signed(ERR_W'(0));
    assign at_end  = (r_x == r_x1) && (r_y == r_y1);

    // byte = x + page * width; bit = row within page
    assign pix_addr = ADDR_W'(r_x)
                    + ADDR_W'(r_y[COORD_W-1:3]) * ADDR_W'(SCREEN_WIDTH);
    assign pix_mask = BYTE_W'(1) << r_y[2:0];

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_sweep == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (item_acc) begin
                    unique case (in_item.kind)
                        KIND_LINE: n_state = ST_PIX_RD;
                        KIND_FILL: n_state = ST_FILL;
                        KIND_READ: n_state = rd_in_range ? ST_READ_WAIT : ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_PIX_RD:    n_state = ST_PIX_WR;
            ST_PIX_WR:    n_state = at_end ? ST_DONE : ST_PIX_RD;
            ST_READ_WAIT: n_state = ST_DONE;
            ST_FILL: begin
                if (r_sweep == LAST_ADDR) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and RAM control
    // ---------------------------------------------------------------
    always_comb begin
        n_sweep     = r_sweep;
        n_fill      = r_fill;
        n_kind      = r_kind;
        n_res_data  = r_res_data;
        n_x         = r_x;
        n_y         = r_y;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_err       = r_err;
        n_white     = r_white;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;
        mem_we      = 1'b0;
        mem_addr    = pix_addr;
        mem_wdata   = r_fill;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_sweep;
                mem_wdata = BYTE_CLEAR;
                n_sweep   = r_sweep + 1'b1;
            end
            ST_IDLE: begin
                // read issued here so the byte is ready next cycle
                mem_addr = ADDR_W'(in_item.read_index);
                if (item_acc) begin
                    n_kind     = in_item.kind;
                    n_res_data = BYTE_CLEAR;
                    n_sweep    = '0;
                    n_fill     = in_item.pen_colour ? BYTE_SET : BYTE_CLEAR;
                    n_x        = cx0;
                    n_y        = cy0;
                    n_x1       = cx1;
                    n_y1       = cy1;
                    n_dx       = in_dx;
                    n_dy       = in_dy;
                    n_sx       = in_sx;
                    n_sy       = in_sy;
                    n_white    = in_item.pen_colour ^ r_inv;
                    n_err      = (in_dx > in_dy) ? $signed({2'b00, half_dx})
                                                 : -$signed({2'b00, half_dy});
                end
            end
            ST_PIX_RD: begin
                mem_addr = pix_addr;
            end
            ST_PIX_WR: begin
                mem_we    = 1'b1;
                mem_addr  = pix_addr;
                mem_wdata = r_white ? (r_rdata | pix_mask) : (r_rdata & ~pix_mask);
                if (!at_end) begin
                    n_err = r_err - err_dec + err_inc;
                    if (step_x) n_x = r_sx ? r_x + 1'b1 : r_x - 1'b1;
                    if (step_y) n_y = r_sy ? r_y + 1'b1 : r_y - 1'b1;
                end
            end
            ST_READ_WAIT: begin
                n_res_data = r_rdata;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_addr  = r_sweep;
                mem_wdata = r_fill;
                n_sweep   = r_sweep + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.read_data = r_res_data;
                    n_out.done_kind = r_kind;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Register update
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_inv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_inv <= i_cfg.payload.draw_inverted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill     <= n_fill;
        r_kind     <= n_kind;
        r_res_data <= n_res_data;
        r_x        <= n_x;
        r_y        <= n_y;
        r_x1       <= n_x1;
        r_y1       <= n_y1;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_err      <= n_err;
        r_white    <= n_white;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire
